>>> hdl/thc_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat heat controller package
// Shared widths, command and register codes, and the target clamp function.
// ----------------------------------------------------------------------------
package thc_pkg;

    // Field widths.
    localparam int TEMP_W    = 10;
    localparam int SENSOR_W  = 11;
    localparam int TIME_W    = 32;
    localparam int CMD_W     = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 11;

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 48;

    // Controller constants.
    localparam int TEMP_STEP         = 5;
    localparam int BOOST_CAP_SECONDS = 14400;
    localparam int SECS_PER_MIN      = 60;

    // Width of the boost interval in seconds (255 minutes fits in 14 bits).
    localparam int INTERVAL_W = 14;
    // Width of the custom target lifetime in seconds (2047 minutes).
    localparam int TIMEOUT_W  = 17;

    // Commands carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_STEP   = 3'd0,
        CMD_MODE   = 3'd1,
        CMD_UP     = 3'd2,
        CMD_DOWN   = 3'd3,
        CMD_SET    = 3'd4,
        CMD_EXTEND = 3'd5
    } cmd_t;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOOST  = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DAY_TEMP       = 3'd0,
        REG_NIGHT_TEMP     = 3'd1,
        REG_OVERSHOOT      = 3'd2,
        REG_UNDERSHOOT     = 3'd3,
        REG_BOOST_MINUTES  = 3'd4,
        REG_CUSTOM_TIMEOUT = 3'd5,
        REG_TARGET_MIN     = 3'd6,
        REG_TARGET_MAX     = 3'd7
    } cfg_idx_t;

    // Clamp a signed target; if min > max, below min gives min, else max.
    function automatic logic [TEMP_W-1:0] clamp_target(
        input logic signed [TEMP_W+1:0] value,
        input logic        [TEMP_W-1:0] tmin,
        input logic        [TEMP_W-1:0] tmax
    );
        logic [TEMP_W-1:0] result;
        if (value < $signed({2'b00, tmin}))
        begin
            result = tmin;
        end
        else if (value > $signed({2'b00, tmax}))
        begin
            result = tmax;
        end
        else
        begin
            result = value[TEMP_W-1:0];
        end
        return result;
    endfunction

endpackage

>>> hdl/thermostat_heat_controller.sv
// ----------------------------------------------------------------------------
// Thermostat heat controller
// On/off heating control with hysteresis, boost timer and custom targets.
// ----------------------------------------------------------------------------
// A command passes through the input register and then the result register,
// which holds its status while the receiver stalls.
// Throughput: one item per cycle unless the receiver stalls; the state update
// happens in the single pass from the input register to the result register.
// Reset: rst_n clears all control state and loads the configuration
// registers with their defaults; the target resets to 5.0 degrees.
module thermostat_heat_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [thc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [thc_pkg::CFG_W-1:0]     cfg_data,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: now_seconds[31:0], measured_temp[42:32], schedule_day[43],
    //        new_mode[45:44], new_target[55:46]
    input  logic [thc_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: cmd[2:0]
    input  logic [thc_pkg::CMD_W-1:0]     s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: heater_on[0], boost_on[1], boost_left_seconds[33:2],
    //        target_now[43:34], mode_shown[45:44], daytime_in_use[46], zero[47]
    output logic [thc_pkg::M_DATA_W-1:0]  m_tdata
);
    import thc_pkg::*;

    // Configuration registers.
    logic [TEMP_W-1:0] day_temp_reg;
    logic [TEMP_W-1:0] night_temp_reg;
    logic [7:0]        overshoot_reg;
    logic [7:0]        undershoot_reg;
    logic [7:0]        boost_minutes_reg;
    logic [10:0]       custom_timeout_reg;
    logic [TEMP_W-1:0] target_min_reg;
    logic [TEMP_W-1:0] target_max_reg;

    // Controller state.
    logic              heating_reg, heating_next;
    logic              boost_reg, boost_next;
    logic              boost_ended_reg, boost_ended_next;
    logic              using_day_reg, using_day_next;
    logic              custom_reg, custom_next;
    logic              normal_reg, normal_next;
    logic [TIME_W-1:0] boost_end_reg, boost_end_next;
    logic [TEMP_W-1:0] target_reg, target_next;
    logic [TIME_W-1:0] custom_time_reg, custom_time_next;

    // Input stage.
    logic                in_valid_reg;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic [SENSOR_W-1:0] in_sensor_reg;
    logic                in_sched_reg;
    logic [MODE_W-1:0]   in_mode_reg;
    logic [TEMP_W-1:0]   in_target_reg;

    // Result stage.
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_temp_reg       <= 10'd210;
            night_temp_reg     <= 10'd180;
            overshoot_reg      <= 8'd2;
            undershoot_reg     <= 8'd2;
            boost_minutes_reg  <= 8'd10;
            custom_timeout_reg <= 11'd0;
            target_min_reg     <= 10'd50;
            target_max_reg     <= 10'd300;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DAY_TEMP:       day_temp_reg       <= cfg_data[TEMP_W-1:0];
                REG_NIGHT_TEMP:     night_temp_reg     <= cfg_data[TEMP_W-1:0];
                REG_OVERSHOOT:      overshoot_reg      <= cfg_data[7:0];
                REG_UNDERSHOOT:     undershoot_reg     <= cfg_data[7:0];
                REG_BOOST_MINUTES:  boost_minutes_reg  <= cfg_data[7:0];
                REG_CUSTOM_TIMEOUT: custom_timeout_reg <= cfg_data[10:0];
                REG_TARGET_MIN:     target_min_reg     <= cfg_data[TEMP_W-1:0];
                REG_TARGET_MAX:     target_max_reg     <= cfg_data[TEMP_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register: loads on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg    <= s_tuser;
            in_now_reg    <= s_tdata[31:0];
            in_sensor_reg <= s_tdata[42:32];
            in_sched_reg  <= s_tdata[43];
            in_mode_reg   <= s_tdata[45:44];
            in_target_reg <= s_tdata[55:46];
        end
    end

    // Command decode and control step.
    always_comb
    begin
        logic [INTERVAL_W-1:0]    interval;
        logic [TIMEOUT_W-1:0]     lifetime;
        logic [TIME_W:0]          deadline;
        logic                     custom_expired;
        logic [TIME_W-1:0]        extended;
        logic [TIME_W-1:0]        boost_left;
        logic signed [TEMP_W+2:0] sensor_s;
        logic signed [TEMP_W+2:0] target_s;
        logic signed [TEMP_W+2:0] stop_level;
        logic signed [TEMP_W+2:0] start_level;
        logic [MODE_W-1:0]        mode_shown;

        heating_next     = heating_reg;
        boost_next       = boost_reg;
        boost_ended_next = boost_ended_reg;
        using_day_next   = using_day_reg;
        custom_next      = custom_reg;
        normal_next      = normal_reg;
        boost_end_next   = boost_end_reg;
        target_next      = target_reg;
        custom_time_next = custom_time_reg;

        interval = INTERVAL_W'(boost_minutes_reg) * INTERVAL_W'(SECS_PER_MIN);
        lifetime = TIMEOUT_W'(custom_timeout_reg) * TIMEOUT_W'(SECS_PER_MIN);
        deadline = {1'b0, custom_time_reg} + (TIME_W+1)'(lifetime);
        custom_expired = custom_reg && (custom_timeout_reg != 11'd0)
                         && ({1'b0, in_now_reg} >= deadline);
        extended = boost_end_reg + TIME_W'(interval);

        sensor_s    = {{2{in_sensor_reg[SENSOR_W-1]}}, in_sensor_reg};
        target_s    = '0;
        stop_level  = '0;
        start_level = '0;

        case (cmd_t'(in_cmd_reg))
            CMD_STEP:
            begin
                // Boost expiry.
                if (boost_reg && (in_now_reg >= boost_end_reg))
                begin
                    boost_next       = 1'b0;
                    boost_ended_next = 1'b1;
                end
                // Schedule reload, zero target or custom target timeout.
                if (normal_reg)
                begin
                    if ((in_sched_reg != using_day_reg) || (target_reg == '0)
                        || custom_expired)
                    begin
                        using_day_next = in_sched_reg;
                        custom_next    = 1'b0;
                        target_next    = in_sched_reg ? day_temp_reg : night_temp_reg;
                    end
                end
                // Hysteresis on the updated target.
                target_s    = $signed({3'b000, target_next});
                stop_level  = target_s + $signed({5'b00000, overshoot_reg});
                start_level = target_s - $signed({5'b00000, undershoot_reg});
                if (heating_reg)
                begin
                    if (!boost_next)
                    begin
                        if (!normal_reg)
                        begin
                            heating_next = 1'b0;
                        end
                        else if ((sensor_s >= target_s) && boost_ended_next)
                        begin
                            heating_next = 1'b0;
                        end
                        else if (sensor_s >= stop_level)
                        begin
                            heating_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    if (boost_next)
                    begin
                        heating_next = 1'b1;
                    end
                    else if (normal_reg && (sensor_s <= start_level))
                    begin
                        heating_next = 1'b1;
                    end
                end
                boost_ended_next = 1'b0;
            end
            CMD_MODE:
            begin
                if (in_mode_reg == MODE_BOOST)
                begin
                    if (!boost_reg)
                    begin
                        boost_end_next = in_now_reg + TIME_W'(interval);
                        boost_next     = 1'b1;
                    end
                end
                else if ((in_mode_reg == MODE_OFF) || (in_mode_reg == MODE_NORMAL))
                begin
                    if (boost_reg)
                    begin
                        boost_next       = 1'b0;
                        boost_ended_next = 1'b1;
                    end
                    normal_next = (in_mode_reg == MODE_NORMAL);
                end
            end
            CMD_UP:
            begin
                if (target_reg < target_max_reg)
                begin
                    target_next = clamp_target(
                        $signed({2'b00, target_reg}) + $signed((TEMP_W+2)'(TEMP_STEP)),
                        target_min_reg, target_max_reg);
                    custom_next      = 1'b1;
                    custom_time_next = in_now_reg;
                end
            end
            CMD_DOWN:
            begin
                if (target_reg > target_min_reg)
                begin
                    target_next = clamp_target(
                        $signed({2'b00, target_reg}) - $signed((TEMP_W+2)'(TEMP_STEP)),
                        target_min_reg, target_max_reg);
                    custom_next      = 1'b1;
                    custom_time_next = in_now_reg;
                end
            end
            CMD_SET:
            begin
                target_next = clamp_target($signed({2'b00, in_target_reg}),
                                           target_min_reg, target_max_reg);
                custom_next      = 1'b1;
                custom_time_next = in_now_reg;
            end
            CMD_EXTEND:
            begin
                // Extension adds to the end time; the cap applies while boosting.
                if (boost_reg && ((extended - in_now_reg) > TIME_W'(BOOST_CAP_SECONDS)))
                begin
                    boost_end_next = in_now_reg + TIME_W'(BOOST_CAP_SECONDS);
                end
                else
                begin
                    boost_end_next = extended;
                end
            end
            default:
            begin
            end
        endcase

        // Status after the command.
        boost_left = boost_next ? (boost_end_next - in_now_reg) : '0;
        mode_shown = boost_next ? MODE_BOOST : (normal_next ? MODE_NORMAL : MODE_OFF);
        out_data_next = {1'b0, using_day_next, mode_shown, target_next,
                         boost_left, boost_next, heating_next};
    end

    // State and result register update on each pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heating_reg     <= 1'b0;
            boost_reg       <= 1'b0;
            boost_ended_reg <= 1'b0;
            using_day_reg   <= 1'b0;
            custom_reg      <= 1'b0;
            normal_reg      <= 1'b0;
            boost_end_reg   <= '0;
            target_reg      <= 10'd50;
            custom_time_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                heating_reg     <= heating_next;
                boost_reg       <= boost_next;
                boost_ended_reg <= boost_ended_next;
                using_day_reg   <= using_day_next;
                custom_reg      <= custom_next;
                normal_reg      <= normal_next;
                boost_end_reg   <= boost_end_next;
                target_reg      <= target_next;
                custom_time_reg <= custom_time_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> dv/tb_thermostat_heat_controller.sv
// ----------------------------------------------------------------------------
// Thermostat heat controller testbench
// Streams commands into the controller and checks every status transfer
// against a cycle-free model of the heater, boost and target logic. A short
// directed table covers the corner cases. Random phases then follow under
// several register settings, with random idling on both sides and one long
// receiver stall.
// ----------------------------------------------------------------------------
module tb_thermostat_heat_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import thc_pkg::*;

    // Command and mode codes that the package does not name.
    localparam logic [CMD_W-1:0]  CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE7 = 3'd7;
    localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;

    localparam int STALL_LIMIT      = 1000;
    localparam int ITEMS_PER_PHASE  = 400;
    localparam int RANDOM_PHASES    = 5;
    localparam int LONG_HOLD_CYCLES = 150;

    // One command as it travels on the input stream.
    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [TIME_W-1:0]         now;
        logic signed [SENSOR_W-1:0] sensor;
        logic                      sched;
        logic [MODE_W-1:0]         nmode;
        logic [TEMP_W-1:0]         ntarget;
    } heat_cmd_t;

    // One status word as it travels on the result stream.
    typedef struct {
        logic              heater;
        logic              boost;
        logic [TIME_W-1:0] left;
        logic [TEMP_W-1:0] target;
        logic [MODE_W-1:0] mode;
        logic              day;
    } heat_status_t;

    // A row of the directed table, optionally with a hand-written status.
    typedef struct {
        heat_cmd_t    item;
        bit           pinned;
        heat_status_t want;
    } heat_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    // Model copy of the configuration registers.
    logic [TEMP_W-1:0] cfg_day, cfg_night, cfg_tmin, cfg_tmax;
    logic [7:0]        cfg_over, cfg_under, cfg_boost_min;
    logic [10:0]       cfg_timeout;

    // Model copy of the controller state.
    logic              heat_st, boost_st, boost_done_st, day_st, custom_st;
    logic [MODE_W-1:0] mode_st;
    logic [TIME_W-1:0] boost_end_st, custom_since_st;
    logic [TEMP_W-1:0] target_st;

    heat_status_t status_due[$];
    heat_row_t    plan[$];
    int           errors = 0;
    int           src_gap_max = 12;
    int           snk_gap_max = 12;
    bit           long_hold_req = 1'b0;
    logic [TIME_W-1:0] wall_now = '0;
    logic         sched_now = 1'b0;
    int           quiet_cycles = 0;

    thermostat_heat_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Reset and default drive of every input but m_tready.
    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Register and state values right after reset.
    function automatic void reset_model();
        cfg_day         = 10'd210;
        cfg_night       = 10'd180;
        cfg_over        = 8'd2;
        cfg_under       = 8'd2;
        cfg_boost_min   = 8'd10;
        cfg_timeout     = 11'd0;
        cfg_tmin        = 10'd50;
        cfg_tmax        = 10'd300;
        heat_st         = 1'b0;
        boost_st        = 1'b0;
        boost_done_st   = 1'b0;
        day_st          = 1'b0;
        custom_st       = 1'b0;
        mode_st         = MODE_OFF;
        boost_end_st    = '0;
        custom_since_st = '0;
        target_st       = 10'd50;
    endfunction

    // Limit a candidate target; with crossed limits, below min gives min, else max.
    function automatic logic [TEMP_W-1:0] bound_target(input int v);
        int lo;
        int hi;
        lo = int'(cfg_tmin);
        hi = int'(cfg_tmax);
        if (v < lo)
        begin
            v = lo;
        end
        else if (v > hi)
        begin
            v = hi;
        end
        return v[TEMP_W-1:0];
    endfunction

    // Hysteresis, boost expiry and schedule reload of the control step.
    function automatic void control_step(input heat_cmd_t it);
        longint unsigned deadline;
        bit              timed_out;
        int              s;
        int              t;
        s = int'(it.sensor);
        if (boost_st && it.now >= boost_end_st)
        begin
            boost_st      = 1'b0;
            boost_done_st = 1'b1;
        end
        if (mode_st == MODE_NORMAL)
        begin
            deadline  = longint'(custom_since_st) + longint'(cfg_timeout) * SECS_PER_MIN;
            timed_out = custom_st && cfg_timeout != '0 && {32'b0, it.now} >= deadline;
            if (it.sched != day_st || target_st == '0 || timed_out)
            begin
                day_st    = it.sched;
                custom_st = 1'b0;
                target_st = it.sched ? cfg_day : cfg_night;
            end
        end
        t = int'(target_st);
        if (heat_st)
        begin
            if (!boost_st)
            begin
                if (mode_st == MODE_OFF)
                begin
                    heat_st = 1'b0;
                end
                else if (s >= t && boost_done_st)
                begin
                    heat_st = 1'b0;
                end
                else if (s >= t + int'(cfg_over))
                begin
                    heat_st = 1'b0;
                end
            end
        end
        else
        begin
            if (boost_st)
            begin
                heat_st = 1'b1;
            end
            else if (mode_st != MODE_OFF && s <= t - int'(cfg_under))
            begin
                heat_st = 1'b1;
            end
        end
        boost_done_st = 1'b0;
    endfunction

    // Apply one command to the model and return the status it produces.
    function automatic heat_status_t heat_status_after(input heat_cmd_t it);
        heat_status_t      st;
        logic [TIME_W-1:0] interval;
        int                t;
        interval = TIME_W'(cfg_boost_min) * TIME_W'(SECS_PER_MIN);
        t        = int'(target_st);
        case (it.cmd)
            CMD_STEP:
            begin
                control_step(it);
            end
            CMD_MODE:
            begin
                if (it.nmode == MODE_BOOST)
                begin
                    if (!boost_st)
                    begin
                        boost_end_st = it.now + interval;
                        boost_st     = 1'b1;
                    end
                end
                else if (it.nmode != MODE_BAD)
                begin
                    if (boost_st)
                    begin
                        boost_st      = 1'b0;
                        boost_done_st = 1'b1;
                    end
                    mode_st = it.nmode;
                end
            end
            CMD_UP:
            begin
                if (t < int'(cfg_tmax))
                begin
                    target_st       = bound_target(t + TEMP_STEP);
                    custom_st       = 1'b1;
                    custom_since_st = it.now;
                end
            end
            CMD_DOWN:
            begin
                if (t > int'(cfg_tmin))
                begin
                    target_st       = bound_target(t - TEMP_STEP);
                    custom_st       = 1'b1;
                    custom_since_st = it.now;
                end
            end
            CMD_SET:
            begin
                target_st       = bound_target(int'(it.ntarget));
                custom_st       = 1'b1;
                custom_since_st = it.now;
            end
            CMD_EXTEND:
            begin
                boost_end_st = boost_end_st + interval;
                if (boost_st && (boost_end_st - it.now) > TIME_W'(BOOST_CAP_SECONDS))
                begin
                    boost_end_st = it.now + TIME_W'(BOOST_CAP_SECONDS);
                end
            end
            default:
            begin
            end
        endcase
        st.heater = heat_st;
        st.boost  = boost_st;
        st.left   = boost_st ? boost_end_st - it.now : '0;
        st.target = target_st;
        st.mode   = boost_st ? MODE_BOOST : mode_st;
        st.day    = day_st;
        return st;
    endfunction

    function automatic void add_row(
        input logic [CMD_W-1:0]  cmd,
        input logic [TIME_W-1:0] now,
        input int                sensor,
        input logic              sched,
        input logic [MODE_W-1:0] nmode,
        input logic [TEMP_W-1:0] ntarget
    );
        heat_row_t r;
        r.item.cmd     = cmd;
        r.item.now     = now;
        r.item.sensor  = sensor[SENSOR_W-1:0];
        r.item.sched   = sched;
        r.item.nmode   = nmode;
        r.item.ntarget = ntarget;
        r.pinned       = 1'b0;
        r.want         = '{default: '0};
        plan.push_back(r);
    endfunction

    // Give the last table row a status written out by hand.
    function automatic void pin_last(
        input logic              heater,
        input logic              boost,
        input logic [TIME_W-1:0] left,
        input logic [TEMP_W-1:0] target,
        input logic [MODE_W-1:0] mode,
        input logic              day
    );
        int k;
        k = plan.size() - 1;
        plan[k].pinned      = 1'b1;
        plan[k].want.heater = heater;
        plan[k].want.boost  = boost;
        plan[k].want.left   = left;
        plan[k].want.target = target;
        plan[k].want.mode   = mode;
        plan[k].want.day    = day;
    endfunction

    // Directed table, run under the reset register values.
    function automatic void build_plan();
        add_row(CMD_STEP, 32'd0, 0, 1'b0, MODE_OFF, 10'd0);
        pin_last(1'b0, 1'b0, 32'd0, 10'd50, MODE_OFF, 1'b0);
        add_row(CMD_SPARE6, 32'd1, 1023, 1'b1, MODE_BOOST, 10'd1023);
        pin_last(1'b0, 1'b0, 32'd0, 10'd50, MODE_OFF, 1'b0);
        add_row(CMD_MODE, 32'd2, 0, 1'b0, MODE_BAD, 10'd0);
        pin_last(1'b0, 1'b0, 32'd0, 10'd50, MODE_OFF, 1'b0);
        add_row(CMD_MODE, 32'd2, 0, 1'b0, MODE_NORMAL, 10'd0);
        pin_last(1'b0, 1'b0, 32'd0, 10'd50, MODE_NORMAL, 1'b0);
        add_row(CMD_STEP, 32'd3, -1024, 1'b1, MODE_OFF, 10'd0);
        pin_last(1'b1, 1'b0, 32'd0, 10'd210, MODE_NORMAL, 1'b1);
        add_row(CMD_SET, 32'd4, 0, 1'b1, MODE_OFF, 10'd1023);
        pin_last(1'b1, 1'b0, 32'd0, 10'd300, MODE_NORMAL, 1'b1);
        add_row(CMD_UP, 32'd5, 0, 1'b1, MODE_OFF, 10'd0);
        pin_last(1'b1, 1'b0, 32'd0, 10'd300, MODE_NORMAL, 1'b1);
        add_row(CMD_SET, 32'd6, 0, 1'b1, MODE_OFF, 10'd0);
        pin_last(1'b1, 1'b0, 32'd0, 10'd50, MODE_NORMAL, 1'b1);
        add_row(CMD_DOWN, 32'd7, 0, 1'b1, MODE_OFF, 10'd0);
        pin_last(1'b1, 1'b0, 32'd0, 10'd50, MODE_NORMAL, 1'b1);
        add_row(CMD_UP, 32'd8, 0, 1'b1, MODE_OFF, 10'd0);
        add_row(CMD_DOWN, 32'd9, 0, 1'b1, MODE_OFF, 10'd0);
        add_row(CMD_STEP, 32'd10, 52, 1'b1, MODE_OFF, 10'd0);
        add_row(CMD_MODE, 32'd100, 0, 1'b1, MODE_BOOST, 10'd0);
        pin_last(1'b0, 1'b1, 32'd600, 10'd50, MODE_BOOST, 1'b1);
        add_row(CMD_EXTEND, 32'd200, 0, 1'b1, MODE_OFF, 10'd0);
        add_row(CMD_STEP, 32'd1000, 1023, 1'b1, MODE_OFF, 10'd0);
        // Boost runs out at this step, so heating stops at the bare target.
        add_row(CMD_STEP, 32'd1300, 1023, 1'b1, MODE_OFF, 10'd0);
        // Extending while boost is off still moves the end time.
        add_row(CMD_EXTEND, 32'd1400, 0, 1'b1, MODE_OFF, 10'd0);
        // Boost end time wraps past the top of the time range.
        add_row(CMD_MODE, 32'hFFFF_FF00, 0, 1'b1, MODE_BOOST, 10'd0);
        add_row(CMD_EXTEND, 32'hFFFF_FF10, 0, 1'b1, MODE_OFF, 10'd0);
        add_row(CMD_STEP, 32'hFFFF_FFFF, 0, 1'b0, MODE_OFF, 10'd0);
        // Boost cancelled by a mode change is seen by the next control step.
        add_row(CMD_MODE, 32'd5, 0, 1'b0, MODE_NORMAL, 10'd0);
        add_row(CMD_MODE, 32'd6, 0, 1'b0, MODE_BOOST, 10'd0);
        add_row(CMD_MODE, 32'd7, 0, 1'b0, MODE_NORMAL, 10'd0);
        add_row(CMD_STEP, 32'd8, 300, 1'b0, MODE_OFF, 10'd0);
        add_row(CMD_MODE, 32'd9, 0, 1'b0, MODE_OFF, 10'd0);
        add_row(CMD_STEP, 32'd10, -1024, 1'b0, MODE_OFF, 10'd0);
        pin_last(1'b0, 1'b0, 32'd0, 10'd180, MODE_OFF, 1'b0);
        add_row(CMD_SPARE7, 32'd11, 0, 1'b1, MODE_NORMAL, 10'd512);
        pin_last(1'b0, 1'b0, 32'd0, 10'd180, MODE_OFF, 1'b0);
    endfunction

    // Random command shaped like a running thermostat: time mostly moves
    // forward in small steps, the sensor mostly sits near the target.
    function automatic heat_cmd_t random_cmd();
        heat_cmd_t it;
        int        r;
        int        s;
        r = int'($urandom_range(0, 99));
        if (r < 2)
        begin
            wall_now = $urandom();
        end
        else if (r < 3)
        begin
            wall_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        end
        else
        begin
            wall_now = wall_now + $urandom_range(0, 90);
        end
        if ($urandom_range(0, 99) < 6)
        begin
            sched_now = ~sched_now;
        end
        r = int'($urandom_range(0, 99));
        if (r < 54)
        begin
            it.cmd = CMD_STEP;
        end
        else if (r < 64)
        begin
            it.cmd = CMD_MODE;
        end
        else if (r < 72)
        begin
            it.cmd = CMD_UP;
        end
        else if (r < 80)
        begin
            it.cmd = CMD_DOWN;
        end
        else if (r < 88)
        begin
            it.cmd = CMD_SET;
        end
        else if (r < 96)
        begin
            it.cmd = CMD_EXTEND;
        end
        else
        begin
            it.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE7 : CMD_SPARE6;
        end
        if ($urandom_range(0, 99) < 80)
        begin
            s = int'(target_st) + int'($urandom_range(0, 60)) - 30;
        end
        else
        begin
            s = int'($urandom_range(0, 2047));
        end
        it.now     = wall_now;
        it.sensor  = s[SENSOR_W-1:0];
        it.sched   = sched_now;
        it.nmode   = MODE_W'($urandom_range(0, 3));
        it.ntarget = TEMP_W'($urandom_range(0, 1023));
        return it;
    endfunction

    // Offer one command and wait for its transfer; the status is predicted
    // at the transfer edge.
    task automatic send_cmd(input heat_cmd_t it, input bit pinned, input heat_status_t want);
        heat_status_t st;
        int           gap;
        gap = int'($urandom_range(0, src_gap_max));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.ntarget, it.nmode, it.sched, it.sensor, it.now};
        s_tuser  <= it.cmd;
        do @(posedge clk); while (s_tready !== 1'b1);
        st = heat_status_after(it);
        status_due.push_back(pinned ? want : st);
    endtask

    // Stop offering and wait until every status has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all eight registers back to back while the block is idle.
    task automatic load_settings(
        input int unsigned day, input int unsigned night,
        input int unsigned over, input int unsigned under,
        input int unsigned boost_min, input int unsigned timeout,
        input int unsigned tmin, input int unsigned tmax
    );
        logic [CFG_W-1:0] vals[8];
        cfg_idx_t         idx;
        vals[0] = CFG_W'(day);
        vals[1] = CFG_W'(night);
        vals[2] = CFG_W'(over);
        vals[3] = CFG_W'(under);
        vals[4] = CFG_W'(boost_min);
        vals[5] = CFG_W'(timeout);
        vals[6] = CFG_W'(tmin);
        vals[7] = CFG_W'(tmax);
        for (int i = 0; i < 8; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
            case (idx)
                REG_DAY_TEMP:       cfg_day       = vals[i][TEMP_W-1:0];
                REG_NIGHT_TEMP:     cfg_night     = vals[i][TEMP_W-1:0];
                REG_OVERSHOOT:      cfg_over      = vals[i][7:0];
                REG_UNDERSHOOT:     cfg_under     = vals[i][7:0];
                REG_BOOST_MINUTES:  cfg_boost_min = vals[i][7:0];
                REG_CUSTOM_TIMEOUT: cfg_timeout   = vals[i][10:0];
                REG_TARGET_MIN:     cfg_tmin      = vals[i][TEMP_W-1:0];
                REG_TARGET_MAX:     cfg_tmax      = vals[i][TEMP_W-1:0];
                default:
                begin
                end
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void compare_field(
        input string name, input logic [31:0] want, input logic [31:0] got
    );
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Compare one status transfer with the oldest prediction.
    function automatic void check_status(input logic [M_DATA_W-1:0] raw);
        heat_status_t want;
        if (status_due.size() == 0)
        begin
            errors++;
            $display("%0t: status with nothing expected, actual %0h", $time, raw);
        end
        else
        begin
            want = status_due.pop_front();
            compare_field("heater_on", 32'(want.heater), 32'(raw[0]));
            compare_field("boost_on", 32'(want.boost), 32'(raw[1]));
            compare_field("boost_left_seconds", want.left, raw[33:2]);
            compare_field("target_now", 32'(want.target), 32'(raw[43:34]));
            compare_field("mode_shown", 32'(want.mode), 32'(raw[45:44]));
            compare_field("daytime_in_use", 32'(want.day), 32'(raw[46]));
        end
    endfunction

    // Result receiver with random back-pressure and one long hold.
    initial
    begin : status_sink
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                gap = LONG_HOLD_CYCLES;
            end
            else
            begin
                gap = int'($urandom_range(0, snk_gap_max));
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            check_status(m_tdata);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst_n !== 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("thermostat_heat_controller test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: directed table, then random phases under new settings.
    initial
    begin : stimulus
        heat_status_t none;
        none = '{default: '0};
        reset_model();
        build_plan();
        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (plan[i])
        begin
            send_cmd(plan[i].item, plan[i].pinned, plan[i].want);
        end
        drain();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    load_settings(210, 180, 2, 2, 10, 3, 50, 300);
                    src_gap_max = 12;
                    snk_gap_max = 12;
                end
                1:
                begin
                    // Everything at zero: zero-length boost, target pinned at zero.
                    load_settings(0, 0, 0, 0, 0, 0, 0, 0);
                    src_gap_max = 0;
                    snk_gap_max = 0;
                end
                2:
                begin
                    load_settings(1023, 1023, 255, 255, 240, 1440, 1023, 1023);
                    src_gap_max = 12;
                    snk_gap_max = 0;
                end
                3:
                begin
                    // Crossed limits: below min gives min, else max.
                    load_settings(400, 150, 5, 10, 1, 1, 600, 200);
                    src_gap_max = 0;
                    snk_gap_max = 12;
                end
                default:
                begin
                    load_settings(220, 170, 3, 1, 30, 2, 100, 900);
                    src_gap_max = 3;
                    snk_gap_max = 12;
                    long_hold_req = 1'b1;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_cmd(random_cmd(), 1'b0, none);
            drain();
        end
        if (errors == 0)
        begin
            $display("thermostat_heat_controller test passed");
        end
        else
        begin
            $display("thermostat_heat_controller test failed");
        end
        $finish;
    end

endmodule
